>>> src/sbq_pkg.sv
package sbq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;

	localparam int CAP_W = 5;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic {
		KIND_ARRIVE = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_SERVED      = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_REJECTED    = 3'd2,
		ST_NEXT        = 3'd3,
		ST_IDLE_AFTER  = 3'd4,
		ST_FINISH_IDLE = 3'd5
	} status_t;

	typedef struct packed {
		logic               kind;
		logic [ID_BITS-1:0] customer_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [ID_BITS-1:0] subject_id;
		logic [ID_BITS-1:0] serving_now;
		logic               server_busy;
	} out_item_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

>>> src/sbq_cell.sv
module sbq_cell
	import sbq_pkg::*;
(
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic [ID_BITS-1:0] push_id,
	input  logic [ID_BITS-1:0] next_id,
	output logic [ID_BITS-1:0] id_out
);

	logic [ID_BITS-1:0] id_q;

	// shift moves the line one cell toward the head, load fills the first free cell
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q <= next_id;
		end else if (ctrl.load) begin
			id_q <= push_id;
		end
	end

	assign id_out = id_q;

endmodule

>>> src/single_server_bounded_queue.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_item   (kind, customer_id)
// out       output     out_valid / out_stall out_item (status, subject_id, serving_now, server_busy)
// cfg       input      cfg_valid / cfg_ready cfg_data (waiting_capacity)
//
// the request is evaluated in the cycle it is accepted and
// its result sits in the output register from the next cycle on
// a new request can be accepted every cycle while in_stall is low; the busy flag,
// the occupancy count and the cell line are updated when a request is accepted
// in_stall is raised only while a result is held and out_stall is high
// reset clears busy flag, serving id, occupancy and output valid, sets capacity to CAP_RESET, not the cells
module single_server_bounded_queue
	import sbq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	// control state
	logic               busy_q;
	logic [ID_BITS-1:0] serving_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CAP_W-1:0]   cap_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// cell line, cell 0 is the head of the waiting line
	logic [ID_BITS-1:0] cell_id [QUEUE_DEPTH];
	cell_ctrl_t         cell_ctrl [QUEUE_DEPTH];

	logic accept;
	logic cfg_write;
	logic push;
	logic pop;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             full;

	// next-state and result of the request being accepted
	logic               busy_d;
	logic [ID_BITS-1:0] serving_d;
	logic [OCC_W-1:0]   occ_d;
	status_t            status_d;
	logic [ID_BITS-1:0] subject_d;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// capacity clamped to 1 .. QUEUE_DEPTH
	assign cap_ext = CMP_W'(cap_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
			eff_cap = CMP_W'(QUEUE_DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full = CMP_W'(occ_q) >= eff_cap;

	// request decode
	always_comb begin
		busy_d    = busy_q;
		serving_d = serving_q;
		occ_d     = occ_q;
		push      = 1'b0;
		pop       = 1'b0;
		status_d  = ST_FINISH_IDLE;
		subject_d = '0;
		unique case (kind_t'(in_item.kind))
			KIND_ARRIVE: begin
				subject_d = in_item.customer_id;
				if (!busy_q) begin
					// idle server takes the customer directly
					busy_d    = 1'b1;
					serving_d = in_item.customer_id;
					status_d  = ST_SERVED;
				end else if (full) begin
					status_d = ST_REJECTED;
				end else begin
					push     = 1'b1;
					occ_d    = occ_q + OCC_W'(1);
					status_d = ST_QUEUED;
				end
			end
			KIND_FINISH: begin
				if (busy_q) begin
					subject_d = serving_q;
					if (occ_q == '0) begin
						busy_d    = 1'b0;
						serving_d = '0;
						status_d  = ST_IDLE_AFTER;
					end else begin
						// head of the line goes into service
						pop       = 1'b1;
						serving_d = cell_id[0];
						occ_d     = occ_q - OCC_W'(1);
						status_d  = ST_NEXT;
					end
				end else begin
					status_d = ST_FINISH_IDLE;
				end
			end
			default: begin
				status_d = ST_FINISH_IDLE;
			end
		endcase
	end

	// the cell line: shift on pop, load the first free cell on push
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0] next_id;

		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign next_id = cell_id[i+1];
		end else begin : g_last
			assign next_id = cell_id[i];
		end

		assign cell_ctrl[i].shift = accept && pop;
		assign cell_ctrl[i].load  = accept && push && (occ_q == OCC_W'(i));

		sbq_cell u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl[i]),
			.push_id (in_item.customer_id),
			.next_id (next_id),
			.id_out  (cell_id[i])
		);
	end

	// control state; a capacity write flushes the waiting line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			serving_q <= '0;
			occ_q     <= '0;
			cap_q     <= CAP_RESET;
		end else begin
			if (accept) begin
				busy_q    <= busy_d;
				serving_q <= serving_d;
			end
			if (cfg_write) begin
				cap_q <= cfg_data;
				occ_q <= '0;
			end else if (accept) begin
				occ_q <= occ_d;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.status      <= status_d;
			out_q.subject_id  <= subject_d;
			out_q.serving_now <= serving_d;
			out_q.server_busy <= busy_d;
		end
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sbq_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 140;
	localparam int PLAN_ROWS   = 26;

	// one row of the directed plan: a request or a capacity write
	typedef enum bit {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic        kind;
		logic [15:0] arg;
		bit          typed;
		out_item_t   want;
	} plan_row_t;

	localparam out_item_t FROM_MODEL = '0;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_item;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	single_server_bounded_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow of the shop: server, waiting ring and capacity register
	logic [CAP_W-1:0]   q_cap;
	logic               q_busy;
	logic [ID_BITS-1:0] q_serving;
	logic [ID_BITS-1:0] q_slots [QUEUE_DEPTH];
	int                 q_head;
	int                 q_tail;
	int                 q_count;

	out_item_t pending_results[$];

	// typed-in expectation for the request now on the bus, if any
	bit        cur_typed;
	out_item_t cur_want;

	bit no_gaps;
	int errors;
	int cycles;
	int checked;
	int driven;
	int settings;
	int status_seen [8];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// capacity actually in force: zero acts as one, above depth acts as depth
	function automatic int cap_in_use();
		if (q_cap == 0)
			return 1;
		if (q_cap > QUEUE_DEPTH)
			return QUEUE_DEPTH;
		return int'(q_cap);
	endfunction

	// a capacity write empties the ring but keeps whoever is in service
	function automatic void flush_ring();
		q_head  = 0;
		q_tail  = cap_in_use() - 1;
		q_count = 0;
	endfunction

	// advance the shadow by one request and return the result it must give
	function automatic out_item_t serve_request(in_item_t req);
		out_item_t          res;
		logic [2:0]         st;
		logic [ID_BITS-1:0] subj;
		int                 cap;
		cap = cap_in_use();
		if (req.kind == KIND_ARRIVE) begin
			subj = req.customer_id;
			if (!q_busy) begin
				// idle server takes the arrival straight away
				q_busy    = 1'b1;
				q_serving = req.customer_id;
				st        = ST_SERVED;
			end else if (q_count >= cap) begin
				st = ST_REJECTED;
			end else begin
				q_tail          = (q_tail + 1 >= cap) ? 0 : q_tail + 1;
				q_slots[q_tail] = req.customer_id;
				q_count++;
				st = ST_QUEUED;
			end
		end else if (q_busy) begin
			subj = q_serving;
			if (q_count == 0) begin
				q_busy    = 1'b0;
				q_serving = '0;
				st        = ST_IDLE_AFTER;
			end else begin
				// head of the ring moves into service
				q_serving = q_slots[q_head];
				q_head    = (q_head + 1 >= cap) ? 0 : q_head + 1;
				q_count--;
				st = ST_NEXT;
			end
		end else begin
			// finish with nobody in the chair: reported only
			subj = '0;
			st   = ST_FINISH_IDLE;
		end
		res.status      = st;
		res.subject_id  = subj;
		res.serving_now = q_busy ? q_serving : '0;
		res.server_busy = q_busy;
		return res;
	endfunction

	// inputs change on the falling edge; the receiver stalls now and then
	always @(negedge clk)
		out_stall <= !no_gaps && ($urandom_range(99) < 8);

	// everything is sampled at the rising edge: results first, then new
	// requests and capacity writes, so a result never meets its own request
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result %h with nothing expected", $time, out_item);
				end else begin
					want = pending_results.pop_front();
					checked++;
					status_seen[out_item.status]++;
					if (out_item.status !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d got %0d",
							$time, want.status, out_item.status);
					end
					if (out_item.subject_id !== want.subject_id) begin
						errors++;
						$display("%0t: subject_id mismatch, expected %h got %h",
							$time, want.subject_id, out_item.subject_id);
					end
					if (out_item.serving_now !== want.serving_now) begin
						errors++;
						$display("%0t: serving_now mismatch, expected %h got %h",
							$time, want.serving_now, out_item.serving_now);
					end
					if (out_item.server_busy !== want.server_busy) begin
						errors++;
						$display("%0t: server_busy mismatch, expected %b got %b",
							$time, want.server_busy, out_item.server_busy);
					end
				end
			end
			if (in_valid && !in_stall) begin
				// shadow always advances, even when the row carries its own answer
				want = serve_request(in_item);
				pending_results.push_back(cur_typed ? cur_want : want);
			end
			if (cfg_valid && cfg_ready) begin
				q_cap = cfg_data;
				flush_ring();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	// with in_valid still high, so back-to-back requests drop valid only for a random gap
	task automatic send_request(input logic kind, input logic [15:0] id,
		input bit typed, input out_item_t want);
		while (!no_gaps && ($urandom_range(99) < 8)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		cur_want  = want;
		in_valid <= 1'b1;
		in_item  <= {kind, id};
		driven++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// capacity goes in only once every request has drained out
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// margin before the capacity write
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		plan_row_t        plan [PLAN_ROWS];
		logic [CAP_W-1:0] phase_cap [PHASES];
		int               arrive_pct;
		logic [15:0]      id;

		plan = '{
			// finish right after reset: nobody to finish
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b1, '{ST_FINISH_IDLE, 16'h0000, 16'h0000, 1'b0}},
			'{ROW_ITEM, KIND_ARRIVE, 16'hFFFF, 1'b1, '{ST_SERVED, 16'hFFFF, 16'hFFFF, 1'b1}},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0000, 1'b1, '{ST_QUEUED, 16'h0000, 16'hFFFF, 1'b1}},
			// id zero moves into service, still busy
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b1, '{ST_NEXT, 16'hFFFF, 16'h0000, 1'b1}},
			// id on a finish is ignored
			'{ROW_ITEM, KIND_FINISH, 16'hFFFF, 1'b1, '{ST_IDLE_AFTER, 16'h0000, 16'h0000, 1'b0}},
			// capacity zero behaves as one slot
			'{ROW_CFG,  KIND_ARRIVE, 16'd0,    1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h1234, 1'b1, '{ST_SERVED, 16'h1234, 16'h1234, 1'b1}},
			'{ROW_ITEM, KIND_ARRIVE, 16'hA5A5, 1'b1, '{ST_QUEUED, 16'hA5A5, 16'h1234, 1'b1}},
			'{ROW_ITEM, KIND_ARRIVE, 16'h5A5A, 1'b1, '{ST_REJECTED, 16'h5A5A, 16'h1234, 1'b1}},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b1, '{ST_NEXT, 16'h1234, 16'hA5A5, 1'b1}},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0F0F, 1'b0, FROM_MODEL},
			// oversize capacity clamps to depth; the write drops the waiting id
			'{ROW_CFG,  KIND_ARRIVE, 16'd31,   1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b1, '{ST_IDLE_AFTER, 16'hA5A5, 16'h0000, 1'b0}},
			// small ring: fill, overflow, then wrap the tail
			'{ROW_CFG,  KIND_ARRIVE, 16'd3,    1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h8001, 1'b1, '{ST_SERVED, 16'h8001, 16'h8001, 1'b1}},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0002, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0004, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0008, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h0010, 1'b1, '{ST_REJECTED, 16'h0010, 16'h8001, 1'b1}},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_ARRIVE, 16'h7FFE, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b0, FROM_MODEL},
			'{ROW_ITEM, KIND_FINISH, 16'h0000, 1'b1, '{ST_FINISH_IDLE, 16'h0000, 16'h0000, 1'b0}}
		};
		// capacity per random phase: extremes, clamped values and two random picks
		phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd0, 5'd0, 5'd16};
		phase_cap[7] = CAP_W'($urandom_range(31));
		phase_cap[8] = CAP_W'($urandom_range(31));

		// every input known from time zero
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_gaps   = 1'b0;
		cur_typed = 1'b0;
		cur_want  = '0;

		// shadow reset state
		q_cap     = CAP_RESET;
		q_busy    = 1'b0;
		q_serving = '0;
		flush_ring();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].op == ROW_CFG)
				write_capacity(plan[r].arg[CAP_W-1:0]);
			else
				send_request(plan[r].kind, plan[r].arg, plan[r].typed, plan[r].want);
		end

		// random phases; heavy-arrival phases push the ring to full
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(phase_cap[ph]);
			no_gaps    = (ph == 4);
			arrive_pct = (ph % 3 == 0) ? 80 : 35 + $urandom_range(40);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(15) == 0)
					id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				else
					id = 16'($urandom);
				send_request(($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_FINISH,
					id, 1'b0, FROM_MODEL);
			end
		end

		in_valid <= 1'b0;
		no_gaps = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d requests driven, %0d results checked over %0d capacity writes",
			driven, checked, settings);
		$display("served %0d queued %0d rejected %0d handed over %0d emptied %0d idle finish %0d",
			status_seen[ST_SERVED], status_seen[ST_QUEUED], status_seen[ST_REJECTED],
			status_seen[ST_NEXT], status_seen[ST_IDLE_AFTER], status_seen[ST_FINISH_IDLE]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

>>> files.f
src/sbq_pkg.sv
src/sbq_cell.sv
src/single_server_bounded_queue.sv
dv/tb_top.sv
